### rtl/dep_pkg.sv
`default_nettype none
package dep_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 3'd0,
        OP_EXTRACT_MIN = 3'd1,
        OP_GET_MIN     = 3'd2,
        OP_EXTRACT_MAX = 3'd3,
        OP_GET_MAX     = 3'd4,
        OP_SIZE        = 3'd5,
        OP_CLEAR       = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_VALUE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop_min;
    } t_cell_ctl;

endpackage
`default_nettype wire

### rtl/dep_if.sv
`default_nettype none
interface dep_in_if
    import dep_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, operation, value, input ready);
    modport sink   (input valid, operation, value, output ready);
endinterface

interface dep_out_if
    import dep_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] result_value;
    logic [COUNT_OUT_W-1:0]   element_count;

    modport source (output valid, status, result_value, element_count, input ready);
    modport sink   (input valid, status, result_value, element_count, output ready);
endinterface
`default_nettype wire

### rtl/dep_cell.sv
`default_nettype none
module dep_cell
    import dep_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                     i_occ,
    input  wire logic                     i_prev_stay,
    input  wire logic signed [DATA_W-1:0] i_prev_value,
    input  wire logic signed [DATA_W-1:0] i_next_value,
    input  wire logic                     i_next_occ,
    output logic signed [DATA_W-1:0]      o_value,
    output logic                          o_stay,
    output logic                          o_last
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    // equal values stay ahead of the new word
    assign o_stay  = i_occ && (r_value <= i_value);
    assign o_last  = i_occ && !i_next_occ;
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (o_stay) begin
                n_value = r_value;
            end else if (i_prev_stay) begin
                n_value = i_value;
            end else begin
                n_value = i_prev_value;
            end
        end else if (i_ctl.pop_min) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

### rtl/double_ended_priority_queue.sv
// The result word of an accepted command is registered and held while the receiver stalls.
// Throughput: one command per cycle unless output stalls; all cells update in parallel.
// Min comes from the head cell, max from the cell flagged last by the fill count.
// Reset (synchronous, active low) clears the fill count and the output valid.
// Cell contents are not cleared; cells past the fill count are never read.
`default_nettype none
module double_ended_priority_queue
    import dep_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dep_in_if.sink    i_in,
    dep_out_if.source o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic                       r_ovalid;
    t_status                    r_status;
    t_status                    n_status;
    logic signed [DATA_W-1:0]   r_result;
    logic signed [DATA_W-1:0]   n_result;
    t_cell_ctl                  cell_ctl;
    logic                       accept;
    logic                       empty;
    logic                       full;
    logic signed [DATA_W-1:0]   max_value;
    logic signed [DATA_W-1:0]   cell_value [CAPACITY];
    logic [CAPACITY-1:0]        cell_occ;
    logic [CAPACITY-1:0]        cell_stay;
    logic [CAPACITY-1:0]        cell_last;

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign empty      = (r_count == '0);
    assign full       = (r_count == CW'(CAPACITY));

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     prev_stay;
        logic signed [DATA_W-1:0] prev_value;
        logic signed [DATA_W-1:0] next_value;
        logic                     next_occ;

        assign cell_occ[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign prev_stay  = 1'b1;
            assign prev_value = '0;
        end else begin : g_body
            assign prev_stay  = cell_stay[g-1];
            assign prev_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_value = '0;
            assign next_occ   = 1'b0;
        end else begin : g_inner
            assign next_value = cell_value[g+1];
            assign next_occ   = cell_occ[g+1];
        end

        dep_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_value      (i_in.value),
            .i_occ        (cell_occ[g]),
            .i_prev_stay  (prev_stay),
            .i_prev_value (prev_value),
            .i_next_value (next_value),
            .i_next_occ   (next_occ),
            .o_value      (cell_value[g]),
            .o_stay       (cell_stay[g]),
            .o_last       (cell_last[g])
        );
    end

    // at most one cell is flagged last
    always_comb begin
        max_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            max_value = max_value | (cell_value[k] & {DATA_W{cell_last[k]}});
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_result = '0;
        cell_ctl = '0;
        if (accept) begin
            unique case (t_op'(i_in.operation))
                OP_INSERT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        cell_ctl.ins = 1'b1;
                        n_count      = r_count + CW'(1);
                    end
                end
                OP_EXTRACT_MIN, OP_GET_MIN: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status = ST_VALUE;
                        n_result = cell_value[0];
                        if (t_op'(i_in.operation) == OP_EXTRACT_MIN) begin
                            cell_ctl.pop_min = 1'b1;
                            n_count          = r_count - CW'(1);
                        end
                    end
                end
                OP_EXTRACT_MAX, OP_GET_MAX: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status = ST_VALUE;
                        n_result = max_value;
                        if (t_op'(i_in.operation) == OP_EXTRACT_MAX) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                OP_CLEAR: n_count = '0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_status;
    assign o_out.result_value  = r_result;
    assign o_out.element_count = COUNT_OUT_W'(r_count);

endmodule
`default_nettype wire

### rtl/dep_checker.sv
`default_nettype none
module dep_checker
    import dep_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [STATUS_W-1:0]      i_status,
    input wire logic signed [DATA_W-1:0] i_result_value,
    input wire logic [COUNT_OUT_W-1:0]   i_element_count
);

    a_no_word_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_result_value) && $stable(i_element_count))
        else $error("stalled result word changed");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_element_count == '0)
        else $error("empty error with nonzero count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_element_count == COUNT_OUT_W'(CAPACITY))
        else $error("full reject below capacity");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_VALUE |-> i_result_value == '0)
        else $error("nonzero result without a returned value");

endmodule

bind double_ended_priority_queue dep_checker #(
    .CAPACITY (CAPACITY)
) u_dep_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_result_value  (o_out.result_value),
    .i_element_count (o_out.element_count)
);
`default_nettype wire

### dv/dep_queue_checker.sv
`timescale 1ns / 100ps
module dep_queue_checker
    import dep_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  logic                   i_cmd_ready,
    input  logic [OP_W-1:0]        i_cmd_op,
    input  logic [DATA_W-1:0]      i_cmd_value,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [STATUS_W-1:0]    i_res_status,
    input  logic [DATA_W-1:0]      i_res_value,
    input  logic [COUNT_OUT_W-1:0] i_res_count,
    output int                     o_pending,
    output int                     o_errors
);

    typedef struct packed {
        t_status                status;
        logic [DATA_W-1:0]      value;
        logic [COUNT_OUT_W-1:0] count;
    } t_reply;

    // shadow copy of the queue, ascending signed order
    logic signed [DATA_W-1:0] shadow_store [CAPACITY];
    int                       shadow_fill = 0;
    t_reply                   pending_replies [$];
    int                       error_total = 0;

    function automatic t_reply apply_command(input logic [OP_W-1:0] op,
                                             input logic signed [DATA_W-1:0] v);
        t_reply r;
        int     pos;
        r.status = ST_OK;
        r.value  = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // equal values stay ahead of the new one
                    pos = shadow_fill;
                    while (pos > 0 && shadow_store[pos-1] > v) begin
                        shadow_store[pos] = shadow_store[pos-1];
                        pos--;
                    end
                    shadow_store[pos] = v;
                    shadow_fill++;
                end
            end
            OP_EXTRACT_MIN, OP_GET_MIN: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_VALUE;
                    r.value  = shadow_store[0];
                    if (op == OP_EXTRACT_MIN) begin
                        for (int i = 0; i < shadow_fill - 1; i++)
                            shadow_store[i] = shadow_store[i+1];
                        shadow_fill--;
                    end
                end
            end
            OP_EXTRACT_MAX, OP_GET_MAX: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_VALUE;
                    r.value  = shadow_store[shadow_fill-1];
                    if (op == OP_EXTRACT_MAX)
                        shadow_fill--;
                end
            end
            OP_CLEAR: begin
                shadow_fill = 0;
            end
            default: begin
                // size and the spare code leave the queue alone
            end
        endcase
        r.count = COUNT_OUT_W'(shadow_fill);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            error_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            pending_replies.delete();
        end else begin
            // a result word always belongs to an earlier command, so pop first
            if (i_res_valid && i_res_ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: no result expected, actual status %0d value %0h count %0d",
                             $time, i_res_status, i_res_value, i_res_count);
                    error_total++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(i_res_status));
                    check_field("result_value", want.value, i_res_value);
                    check_field("element_count", DATA_W'(want.count), DATA_W'(i_res_count));
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                pending_replies.push_back(apply_command(i_cmd_op, i_cmd_value));
        end
        o_pending <= pending_replies.size();
        o_errors  <= error_total;
    end

endmodule

### dv/double_ended_priority_queue_test.sv
`timescale 1ns / 100ps
module double_ended_priority_queue_test;
    import dep_pkg::*;

    localparam int              RANDOM_ITEMS = 800;
    localparam int              CYCLE_LIMIT  = 500000;
    localparam logic [OP_W-1:0] OP_UNUSED    = 3'd7;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_phase;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   errors;
    int   cycles = 0;
    int   stall_left = 0;
    bit   steady = 1'b0;

    dep_in_if  in_ch();
    dep_out_if out_ch();

    double_ended_priority_queue #(
        .CAPACITY(CAPACITY_DEF)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    dep_queue_checker #(
        .CAPACITY(CAPACITY_DEF)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (in_ch.valid),
        .i_cmd_ready (in_ch.ready),
        .i_cmd_op    (in_ch.operation),
        .i_cmd_value (in_ch.value),
        .i_res_valid (out_ch.valid),
        .i_res_ready (out_ch.ready),
        .i_res_status(out_ch.status),
        .i_res_value (out_ch.result_value),
        .i_res_count (out_ch.element_count),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(9, 40);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    function automatic logic [DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3, 4: return $urandom;
            5, 6, 7:       return $urandom_range(0, 15) - 8; // crowd of duplicates
            8: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: begin
                if ($urandom_range(0, 1))
                    return 32'h8000_0000 + $urandom_range(0, 3);
                else
                    return 32'h7fff_ffff - $urandom_range(0, 3);
            end
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                if (r < 85)      return OP_INSERT;
                else if (r < 89) return OP_GET_MIN;
                else if (r < 93) return OP_GET_MAX;
                else if (r < 97) return OP_SIZE;
                else             return OP_EXTRACT_MIN;
            end
            PH_DRAIN: begin
                if (r < 40)      return OP_EXTRACT_MIN;
                else if (r < 80) return OP_EXTRACT_MAX;
                else if (r < 85) return OP_GET_MIN;
                else if (r < 90) return OP_GET_MAX;
                else if (r < 95) return OP_SIZE;
                else             return OP_INSERT;
            end
            default: begin
                if (r < 35)      return OP_INSERT;
                else if (r < 45) return OP_EXTRACT_MIN;
                else if (r < 55) return OP_GET_MIN;
                else if (r < 65) return OP_EXTRACT_MAX;
                else if (r < 75) return OP_GET_MAX;
                else if (r < 85) return OP_SIZE;
                else if (r < 88) return OP_CLEAR;
                else if (r < 90) return OP_UNUSED;
                else             return OP_INSERT;
            end
        endcase
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] v);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.value     <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        gap = (steady || $urandom_range(0, 1)) ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every result word is back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int     sent;
        int     len;
        t_phase ph;
        bit     first;
        sent            = 0;
        first           = 1'b1;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_INSERT;
        in_ch.value     = '0;
        out_ch.ready    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue errors, then extremes and duplicates, the spare code and clear
        send_cmd(OP_GET_MIN, 32'h0);
        send_cmd(OP_EXTRACT_MIN, 32'h0);
        send_cmd(OP_GET_MAX, 32'h0);
        send_cmd(OP_EXTRACT_MAX, 32'h0);
        send_cmd(OP_SIZE, 32'hffff_ffff);
        send_cmd(OP_INSERT, 32'h8000_0000);
        send_cmd(OP_INSERT, 32'h7fff_ffff);
        send_cmd(OP_INSERT, 32'hffff_ffff);
        send_cmd(OP_INSERT, 32'h0000_0000);
        send_cmd(OP_INSERT, 32'hffff_ffff);
        send_cmd(OP_GET_MIN, 32'h0);
        send_cmd(OP_GET_MAX, 32'h0);
        send_cmd(OP_SIZE, 32'h0);
        send_cmd(OP_UNUSED, 32'h1234_5678);
        send_cmd(OP_EXTRACT_MAX, 32'h0);
        send_cmd(OP_EXTRACT_MIN, 32'h0);
        send_cmd(OP_EXTRACT_MIN, 32'h0);
        send_cmd(OP_EXTRACT_MAX, 32'h0);
        send_cmd(OP_GET_MIN, 32'h0);
        send_cmd(OP_CLEAR, 32'h0);
        send_cmd(OP_SIZE, 32'h0);
        send_cmd(OP_INSERT, 32'h0000_0005);
        send_cmd(OP_CLEAR, 32'h0);
        send_cmd(OP_GET_MAX, 32'h0);
        drain_results();

        while (sent < RANDOM_ITEMS) begin
            ph     = first ? PH_FILL : t_phase'($urandom_range(0, 2));
            len    = $urandom_range(60, 110);
            steady = ($urandom_range(0, 3) == 0);
            repeat (len) begin
                send_cmd(pick_op(ph), rand_value());
                sent++;
            end
            if (first || $urandom_range(0, 2) == 0)
                drain_results();
            first = 1'b0;
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
